>>> rtl/core/ugbt_pkg.sv
`default_nettype none

package ugbt_pkg;

    // table geometry
    localparam int NUM_CELLS = 1024;
    localparam int CELL_W    = 10;
    localparam int SLOTS     = 32;
    localparam int SLOT_W    = 5;
    localparam int FILL_W    = 6;
    localparam int NUM_OBJ   = 256;
    localparam int OBJ_W     = 8;
    localparam int ENT_AW    = CELL_W + SLOT_W;

    // coordinate divide: non-negative 16-bit coordinates carry 15 magnitude bits
    localparam int DIV_W     = 15;
    localparam int CSIZE_W   = 12;
    localparam int GRID_W    = 6;
    localparam int LOC_W     = 2 * GRID_W;

    // operations
    localparam logic [1:0] OP_INS_POS  = 2'd0;
    localparam logic [1:0] OP_INS_CELL = 2'd1;
    localparam logic [1:0] OP_REMOVE   = 2'd2;
    localparam logic [1:0] OP_LOCATE   = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_FULL       = 3'd1;
    localparam logic [2:0] ST_NOT_PLACED = 3'd2;
    localparam logic [2:0] ST_ALREADY    = 3'd3;
    localparam logic [2:0] ST_BAD_CELL   = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_CELL_SIZE = 2'd0;
    localparam logic [1:0] CFG_COLUMNS   = 2'd1;
    localparam logic [1:0] CFG_ROWS      = 2'd2;

    typedef struct packed {
        logic [1:0]        operation;
        logic [OBJ_W-1:0]  object_id;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [CELL_W-1:0] target_cell;
    } ugbt_in_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [CELL_W-1:0] cell_index;
        logic [SLOT_W-1:0] slot_index;
        logic              moved_valid;
        logic [OBJ_W-1:0]  moved_object;
        logic [SLOT_W-1:0] moved_slot;
    } ugbt_out_t;

endpackage

`default_nettype wire

>>> rtl/core/ugbt_div.sv
`default_nettype none

// two restoring dividers sharing one step counter, one quotient bit per cycle
module ugbt_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [ugbt_pkg::DIV_W-1:0]   dividend_x,
    input  wire logic [ugbt_pkg::DIV_W-1:0]   dividend_y,
    input  wire logic [ugbt_pkg::CSIZE_W-1:0] divisor,
    output logic                              done,
    output logic [ugbt_pkg::DIV_W-1:0]        quot_x,
    output logic [ugbt_pkg::DIV_W-1:0]        quot_y
);
    import ugbt_pkg::*;

    localparam logic [3:0] LAST_STEP = 4'(DIV_W - 1);

    logic               run_reg, run_next;
    logic               done_reg, done_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic [DIV_W-1:0]   qx_reg, qx_next, qy_reg, qy_next;
    logic [CSIZE_W-1:0] rx_reg, rx_next, ry_reg, ry_next, d_reg, d_next;
    logic [CSIZE_W:0]   trial_x, trial_y, diff_x, diff_y;
    logic               ge_x, ge_y;

    always_comb
    begin
        trial_x = {rx_reg, qx_reg[DIV_W-1]};
        trial_y = {ry_reg, qy_reg[DIV_W-1]};
        ge_x    = trial_x >= {1'b0, d_reg};
        ge_y    = trial_y >= {1'b0, d_reg};
        diff_x  = trial_x - {1'b0, d_reg};
        diff_y  = trial_y - {1'b0, d_reg};

        run_next  = run_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        qx_next   = qx_reg;
        qy_next   = qy_reg;
        rx_next   = rx_reg;
        ry_next   = ry_reg;
        d_next    = d_reg;

        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            qx_next  = dividend_x;
            qy_next  = dividend_y;
            rx_next  = '0;
            ry_next  = '0;
            d_next   = divisor;
        end
        else if (run_reg)
        begin
            rx_next  = ge_x ? diff_x[CSIZE_W-1:0] : trial_x[CSIZE_W-1:0];
            ry_next  = ge_y ? diff_y[CSIZE_W-1:0] : trial_y[CSIZE_W-1:0];
            qx_next  = {qx_reg[DIV_W-2:0], ge_x};
            qy_next  = {qy_reg[DIV_W-2:0], ge_y};
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == LAST_STEP)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qx_reg <= qx_next;
        qy_reg <= qy_next;
        rx_reg <= rx_next;
        ry_reg <= ry_next;
        d_reg  <= d_next;
    end

    assign done   = done_reg;
    assign quot_x = qx_reg;
    assign quot_y = qy_reg;

endmodule

`default_nettype wire

>>> rtl/core/uniform_grid_bucket_table.sv
// uniform grid bucket table: broad-phase binning of objects into square cells
//
// input channel (in_valid / in_stall / in_data): one transaction per operation,
// insert by position, insert into a named cell, remove, or locate a position
// output channel (out_valid / out_stall / out_data): exactly one result
// transaction per input transaction, in order
// config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): cell size,
// columns, rows; cfg_ready is always high, write only while the table is idle
//
// one operation is worked on at a time; a new one is taken once the previous
// result sits in the output register, even if the receiver still stalls it
// insert into a cell skips the divider; insert by position, remove and locate
// wait on the 15-step coordinate divider; every operation but locate then runs
// a chain of dependent reads (object location, cell fill, and for a remove the
// last cell entry); the next input can be taken in the following cycle
// a stalled result holds in the output register; the next result waits behind it
//
// after reset the cell fill memory is swept to zero, one cell per cycle, over
// all 1024 cells; no input transaction is taken during the sweep
`default_nettype none

module uniform_grid_bucket_table (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire ugbt_pkg::ugbt_in_t        in_data,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output ugbt_pkg::ugbt_out_t            out_data,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [1:0]                cfg_index,
    input  wire logic [ugbt_pkg::CSIZE_W-1:0] cfg_data
);
    import ugbt_pkg::*;

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_DIV   = 10'b0000000100,
        S_MUL   = 10'b0000001000,
        S_ADD   = 10'b0000010000,
        S_LOOK  = 10'b0000100000,
        S_LOC   = 10'b0001000000,
        S_FILL  = 10'b0010000000,
        S_ENTRY = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [CSIZE_W-1:0] cell_size_reg;
    logic [GRID_W-1:0]  columns_reg, rows_reg;
    logic [CSIZE_W-1:0] cs_eff;
    logic [GRID_W-1:0]  cols_eff, rows_eff;

    // operation context
    ugbt_in_t          in_reg, in_next;
    logic [LOC_W-1:0]  cell_reg, cell_next;    // wide enough for an off-table cell
    logic              bad_reg, bad_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [LOC_W-1:0]  prod_reg, prod_next;
    logic [GRID_W-1:0] cx_reg, cx_next;
    logic [CELL_W-1:0] clr_reg, clr_next;
    ugbt_out_t         res_reg, res_next;
    ugbt_out_t         out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    // placed flags live in flip-flops so reset clears them at once
    logic [NUM_OBJ-1:0] placed_reg, placed_next;

    // memories
    logic [FILL_W-1:0]        fill_mem [NUM_CELLS];
    logic [OBJ_W-1:0]         ent_mem  [NUM_CELLS*SLOTS];
    logic [CELL_W+SLOT_W-1:0] loc_mem  [NUM_OBJ];

    logic                     fill_we;
    logic [CELL_W-1:0]        fill_waddr, fill_raddr;
    logic [FILL_W-1:0]        fill_wdata, fill_q;
    logic                     ent_we;
    logic [ENT_AW-1:0]        ent_waddr, ent_raddr;
    logic [OBJ_W-1:0]         ent_wdata, ent_q;
    logic                     loc_we;
    logic [OBJ_W-1:0]         loc_waddr, loc_raddr;
    logic [CELL_W+SLOT_W-1:0] loc_wdata, loc_q;

    // divider
    logic               div_start, div_done;
    logic [DIV_W-1:0]   quot_x, quot_y;

    logic               placed;
    logic [CELL_W-1:0]  loc_cell;
    logic [SLOT_W-1:0]  loc_slot;
    logic [FILL_W-1:0]  fill_dec;
    logic [GRID_W-1:0]  cx, cy;
    logic [LOC_W-1:0]   sum;
    logic               is_insert;

    // cell coordinate: negative goes to zero, beyond the grid to the last cell
    function automatic logic [GRID_W-1:0] clamp_coord(
        input logic             neg,
        input logic [DIV_W-1:0] q,
        input logic [GRID_W-1:0] count
    );
        logic [GRID_W-1:0] r;
        if (neg)
            r = '0;
        else if (q >= DIV_W'(count))
            r = count - GRID_W'(1);
        else
            r = q[GRID_W-1:0];
        return r;
    endfunction

    ugbt_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .dividend_x (in_data.pos_x[DIV_W-1:0]),
        .dividend_y (in_data.pos_y[DIV_W-1:0]),
        .divisor    (cs_eff),
        .done       (div_done),
        .quot_x     (quot_x),
        .quot_y     (quot_y)
    );

    // zero registers act as one
    assign cs_eff   = (cell_size_reg == '0) ? CSIZE_W'(1) : cell_size_reg;
    assign cols_eff = (columns_reg == '0) ? GRID_W'(1) : columns_reg;
    assign rows_eff = (rows_reg == '0) ? GRID_W'(1) : rows_reg;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign placed    = placed_reg[in_reg.object_id];
    assign loc_cell  = loc_q[CELL_W+SLOT_W-1:SLOT_W];
    assign loc_slot  = loc_q[SLOT_W-1:0];
    assign fill_dec  = fill_q - FILL_W'(1);
    assign cx        = clamp_coord(in_reg.pos_x[15], quot_x, cols_eff);
    assign cy        = clamp_coord(in_reg.pos_y[15], quot_y, rows_eff);
    assign sum       = prod_reg + LOC_W'(cx_reg);
    assign is_insert = (in_reg.operation == OP_INS_POS) || (in_reg.operation == OP_INS_CELL);

    always_comb
    begin
        state_next     = state_reg;
        in_next        = in_reg;
        cell_next      = cell_reg;
        bad_next       = bad_reg;
        slot_next      = slot_reg;
        fill_next      = fill_reg;
        prod_next      = prod_reg;
        cx_next        = cx_reg;
        clr_next       = clr_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        placed_next    = placed_reg;
        div_start      = 1'b0;

        fill_we    = 1'b0;
        fill_waddr = cell_reg[CELL_W-1:0];
        fill_wdata = '0;
        fill_raddr = cell_reg[CELL_W-1:0];
        ent_we     = 1'b0;
        ent_waddr  = {cell_reg[CELL_W-1:0], slot_reg};
        ent_wdata  = '0;
        ent_raddr  = {cell_reg[CELL_W-1:0], fill_dec[SLOT_W-1:0]};
        loc_we     = 1'b0;
        loc_waddr  = in_reg.object_id;
        loc_wdata  = '0;
        loc_raddr  = in_reg.object_id;

        case (state_reg)
            S_CLEAR:
            begin
                fill_we    = 1'b1;
                fill_waddr = clr_reg;
                clr_next   = clr_reg + CELL_W'(1);
                if (&clr_reg)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    in_next = in_data;
                    if (in_data.operation == OP_INS_CELL)
                        state_next = S_MUL;
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                if (in_reg.operation == OP_INS_CELL)
                    prod_next = LOC_W'(cols_eff) * LOC_W'(rows_eff);
                else
                    prod_next = LOC_W'(cy) * LOC_W'(cols_eff);
                cx_next    = cx;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                if (in_reg.operation == OP_INS_CELL)
                begin
                    cell_next = LOC_W'(in_reg.target_cell);
                    bad_next  = LOC_W'(in_reg.target_cell) >= prod_reg;
                end
                else
                begin
                    cell_next = sum;
                    bad_next  = sum >= LOC_W'(NUM_CELLS);
                end
                state_next = S_LOOK;
            end
            S_LOOK:
            begin
                res_next            = '0;
                res_next.cell_index = cell_reg[CELL_W-1:0];
                if (in_reg.operation == OP_LOCATE)
                begin
                    res_next.status = bad_reg ? ST_BAD_CELL : ST_OK;
                    state_next      = S_DONE;
                end
                else if (in_reg.operation == OP_REMOVE)
                begin
                    if (!placed)
                    begin
                        res_next.status     = ST_NOT_PLACED;
                        res_next.cell_index = '0;
                        state_next          = S_DONE;
                    end
                    else
                        state_next = S_LOC;
                end
                else if (placed)
                    state_next = S_LOC;
                else if (bad_reg)
                begin
                    res_next.status = ST_BAD_CELL;
                    state_next      = S_DONE;
                end
                else
                    state_next = S_FILL;
            end
            S_LOC:
            begin
                if (is_insert)
                begin
                    res_next.status     = ST_ALREADY;
                    res_next.cell_index = loc_cell;
                    res_next.slot_index = loc_slot;
                    state_next          = S_DONE;
                end
                else
                begin
                    cell_next  = LOC_W'(loc_cell);
                    slot_next  = loc_slot;
                    fill_raddr = loc_cell;
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                if (is_insert)
                begin
                    if (fill_q >= FILL_W'(SLOTS))
                        res_next.status = ST_FULL;
                    else
                    begin
                        ent_we     = 1'b1;
                        ent_waddr  = {cell_reg[CELL_W-1:0], fill_q[SLOT_W-1:0]};
                        ent_wdata  = in_reg.object_id;
                        fill_we    = 1'b1;
                        fill_wdata = fill_q + FILL_W'(1);
                        loc_we     = 1'b1;
                        loc_wdata  = {cell_reg[CELL_W-1:0], fill_q[SLOT_W-1:0]};
                        placed_next[in_reg.object_id] = 1'b1;
                        res_next.status     = ST_OK;
                        res_next.slot_index = fill_q[SLOT_W-1:0];
                    end
                    state_next = S_DONE;
                end
                else if (fill_q == '0)
                begin
                    placed_next[in_reg.object_id] = 1'b0;
                    res_next.status     = ST_OK;
                    res_next.cell_index = cell_reg[CELL_W-1:0];
                    res_next.slot_index = slot_reg;
                    state_next          = S_DONE;
                end
                else
                begin
                    // fetch the last entry of the cell to fill the freed slot
                    fill_next  = fill_dec;
                    state_next = S_ENTRY;
                end
            end
            S_ENTRY:
            begin
                ent_we     = 1'b1;
                ent_wdata  = ent_q;
                fill_we    = 1'b1;
                fill_wdata = fill_reg;
                placed_next[in_reg.object_id] = 1'b1 == 1'b0;
                res_next.status     = ST_OK;
                res_next.cell_index = cell_reg[CELL_W-1:0];
                res_next.slot_index = slot_reg;
                if (FILL_W'(slot_reg) < fill_reg)
                begin
                    loc_we                = 1'b1;
                    loc_waddr             = ent_q;
                    loc_wdata             = {cell_reg[CELL_W-1:0], slot_reg};
                    res_next.moved_valid  = 1'b1;
                    res_next.moved_object = ent_q;
                    res_next.moved_slot   = slot_reg;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            placed_reg    <= '0;
            cell_size_reg <= CSIZE_W'(32);
            columns_reg   <= GRID_W'(32);
            rows_reg      <= GRID_W'(32);
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            placed_reg    <= placed_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CELL_SIZE: cell_size_reg <= cfg_data;
                    CFG_COLUMNS:   columns_reg   <= cfg_data[GRID_W-1:0];
                    CFG_ROWS:      rows_reg      <= cfg_data[GRID_W-1:0];
                    default:       ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        in_reg   <= in_next;
        cell_reg <= cell_next;
        bad_reg  <= bad_next;
        slot_reg <= slot_next;
        fill_reg <= fill_next;
        prod_reg <= prod_next;
        cx_reg   <= cx_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    // cell fill counts
    always_ff @(posedge clk)
    begin
        if (fill_we)
            fill_mem[fill_waddr] <= fill_wdata;
        fill_q <= fill_mem[fill_raddr];
    end

    // cell slot lists
    always_ff @(posedge clk)
    begin
        if (ent_we)
            ent_mem[ent_waddr] <= ent_wdata;
        ent_q <= ent_mem[ent_raddr];
    end

    // owning cell and slot of each object
    always_ff @(posedge clk)
    begin
        if (loc_we)
            loc_mem[loc_waddr] <= loc_wdata;
        loc_q <= loc_mem[loc_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/core/ugbt_checker.sv
`default_nettype none

module ugbt_checker (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 out_valid,
    input wire logic                 out_stall,
    input wire ugbt_pkg::ugbt_out_t  out_data
);
    import ugbt_pkg::*;

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // only the five status codes appear
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status == ST_OK || out_data.status == ST_FULL
            || out_data.status == ST_NOT_PLACED || out_data.status == ST_ALREADY
            || out_data.status == ST_BAD_CELL))
        else $error("illegal status code");

    // a moved object is only reported by a successful removal
    a_moved_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.moved_valid |-> out_data.status == ST_OK)
        else $error("moved object on failed operation");

    // unplaced removal reports cell zero and nothing moved
    a_not_placed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_NOT_PLACED
            |-> out_data.cell_index == '0 && !out_data.moved_valid)
        else $error("not placed result carries data");

endmodule

bind uniform_grid_bucket_table ugbt_checker u_ugbt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire
